@@ design/dsp_pkg.sv @@
// Shared types and constants for the DAG shortest-path engine.
`timescale 1ns / 1ps
package dsp_pkg;

  localparam logic       CMD_ADD  = 1'b0;
  localparam logic       CMD_RUN  = 1'b1;
  localparam logic [15:0] DIST_MAX = 16'd32767;
  localparam logic [15:0] DIST_NONE = 16'hFFFF;

  typedef struct packed {
    logic [4:0] src;
    logic [4:0] dst;
    logic [9:0] wt;
  } edge_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT,
    S_SCAN,
    S_EDGE,
    S_RESTORE,
    S_ORDPOP,
    S_ORD,
    S_DU,
    S_RSCAN,
    S_REDGE,
    S_RCMP,
    S_EMIT,
    S_LOAD,
    S_OWAIT
  } state_t;

endpackage

@@ design/dsp_if.sv @@
// Valid/ready channel interfaces for edge commands and distance results.
`timescale 1ns / 1ps
interface dsp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [4:0] edge_from;
  logic [4:0] edge_to;
  logic [9:0] edge_weight;

  modport source (output valid, cmd, edge_from, edge_to, edge_weight, input ready);
  modport sink (input valid, cmd, edge_from, edge_to, edge_weight, output ready);
endinterface

interface dsp_out_if;
  logic              valid;
  logic              ready;
  logic [4:0]        node_index;
  logic signed [15:0] distance;
  logic              overflow;
  logic              last_node;

  modport source (output valid, node_index, distance, overflow, last_node, input ready);
  modport sink (input valid, node_index, distance, overflow, last_node, output ready);
endinterface

@@ design/dag_shortest_path.sv @@
// DAG single-source shortest path: edge loading, topological search, relaxation.
// Edges are loaded one per cycle (cmd 0) into an edge RAM; dropped edges (store
// full or endpoint >= num_nodes) set the overflow flag. A compute item (cmd 1)
// runs an iterative depth-first search whose frames live in a stack RAM and whose
// finish order goes to an order RAM, then relaxes each reachable node's edges in
// reverse finish order against a distance RAM. Every edge visit is a read on the
// single edge RAM read port; the search scans all stored edges for each node it
// visits, relaxation scans them again for each reachable node, and each result
// is emitted through the EMIT, LOAD and OWAIT states. Results come out in node
// order, one per node below num_nodes; afterwards the edge store is empty. No
// input is taken during a compute item.
`timescale 1ns / 1ps
module dag_shortest_path #(
  parameter int MAX_NODES = 32,
  parameter int MAX_EDGES = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  dsp_in_if.sink     in_ch,
  dsp_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [5:0] cfg_data
);
  import dsp_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int SW  = NW + EW;

  state_t state_r, state_nxt;
  logic [5:0]           nodes_r;
  logic [EW-1:0]        ecnt_r, ecnt_nxt;
  logic                 drop_r, drop_nxt;
  logic [MAX_NODES-1:0] visited_r, visited_nxt;
  logic [MAX_NODES-1:0] reach_r, reach_nxt;
  logic [NCW-1:0]       root_r, root_nxt;
  logic [NCW-1:0]       top_r, top_nxt;
  logic [NCW-1:0]       depth_r, depth_nxt;
  logic [NW-1:0]        cur_u_r, cur_u_nxt;
  logic [EW-1:0]        cur_i_r, cur_i_nxt;
  logic [NW-1:0]        v_r, v_nxt;
  logic [15:0]          cand_r, cand_nxt;
  logic [15:0]          du_r, du_nxt;
  logic [4:0]           o_node_r, o_node_nxt;
  logic [15:0]          o_dist_r, o_dist_nxt;
  logic                 o_ovf_r, o_ovf_nxt;
  logic                 o_last_r, o_last_nxt;

  logic [NCW-1:0] n_lim;
  logic           in_xfer, out_xfer;

  // RAM ports
  logic          e_we;
  logic [EAW-1:0] e_waddr, e_raddr;
  edge_t         e_wdata, e_rdata;
  logic          s_we;
  logic [NW-1:0] s_waddr, s_raddr;
  logic [SW-1:0] s_wdata, s_rdata;
  logic          o_we;
  logic [NW-1:0] o_waddr, o_raddr;
  logic [NW-1:0] o_wdata, o_rdata;
  logic          d_we;
  logic [NW-1:0] d_waddr, d_raddr;
  logic [15:0]   d_wdata, d_rdata;

  // decoded edge checks
  logic          scan_done, add_bad, edge_from_u, edge_to_ok, push_ok;
  logic [NW-1:0] edge_v;
  logic [15:0]   sum;

  dsp_ram #(.WIDTH($bits(edge_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata)
  );
  dsp_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_stack_ram (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );
  dsp_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_order_ram (
    .clk, .we(o_we), .waddr(o_waddr), .wdata(o_wdata), .raddr(o_raddr), .rdata(o_rdata)
  );
  dsp_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_dist_ram (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(d_raddr), .rdata(d_rdata)
  );

  always_comb begin
    if (nodes_r == 6'd0) begin
      n_lim = NCW'(1);
    end else if (32'(nodes_r) > MAX_NODES) begin
      n_lim = NCW'(MAX_NODES);
    end else begin
      n_lim = NCW'(nodes_r);
    end
  end

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_xfer  = out_ch.valid && out_ch.ready;
  assign scan_done = (cur_i_r == ecnt_r);
  assign add_bad   = (ecnt_r == EW'(MAX_EDGES)) || (32'(in_ch.edge_from) >= 32'(n_lim)) ||
                     (32'(in_ch.edge_to) >= 32'(n_lim));
  assign edge_v      = NW'(e_rdata.dst);
  assign edge_from_u = (32'(e_rdata.src) == 32'(cur_u_r)) && (32'(e_rdata.src) < 32'(n_lim));
  assign edge_to_ok  = (32'(e_rdata.dst) < 32'(n_lim));
  assign push_ok     = edge_from_u && edge_to_ok && !visited_r[edge_v];
  assign sum         = {1'b0, du_r[14:0]} + 16'(e_rdata.wt);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && in_ch.cmd == CMD_RUN) state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (root_r == n_lim) begin
          state_nxt = S_ORDPOP;
        end else if (!visited_r[NW'(root_r)]) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!scan_done) begin
          state_nxt = S_EDGE;
        end else if (top_r > NCW'(1)) begin
          state_nxt = S_RESTORE;
        end else begin
          state_nxt = S_ROOT;
        end
      end
      S_EDGE:    state_nxt = S_SCAN;
      S_RESTORE: state_nxt = S_SCAN;
      S_ORDPOP:  state_nxt = (depth_r == '0) ? S_EMIT : S_ORD;
      S_ORD: begin
        if (32'(o_rdata) < 32'(n_lim) && reach_r[o_rdata]) begin
          state_nxt = S_DU;
        end else begin
          state_nxt = S_ORDPOP;
        end
      end
      S_DU:    state_nxt = S_RSCAN;
      S_RSCAN: state_nxt = scan_done ? S_ORDPOP : S_REDGE;
      S_REDGE: state_nxt = (edge_from_u && edge_to_ok) ? S_RCMP : S_RSCAN;
      S_RCMP:  state_nxt = S_RSCAN;
      S_EMIT:  state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_OWAIT;
      S_OWAIT: begin
        if (out_xfer) state_nxt = o_last_r ? S_IDLE : S_EMIT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    ecnt_nxt    = ecnt_r;
    drop_nxt    = drop_r;
    visited_nxt = visited_r;
    reach_nxt   = reach_r;
    root_nxt    = root_r;
    top_nxt     = top_r;
    depth_nxt   = depth_r;
    cur_u_nxt   = cur_u_r;
    cur_i_nxt   = cur_i_r;
    v_nxt       = v_r;
    cand_nxt    = cand_r;
    du_nxt      = du_r;
    o_node_nxt  = o_node_r;
    o_dist_nxt  = o_dist_r;
    o_ovf_nxt   = o_ovf_r;
    o_last_nxt  = o_last_r;
    in_ch.ready = 1'b0;
    e_we = 1'b0; e_waddr = ecnt_r[EAW-1:0]; e_raddr = cur_i_r[EAW-1:0];
    e_wdata = '{src: in_ch.edge_from, dst: in_ch.edge_to, wt: in_ch.edge_weight};
    s_we = 1'b0; s_waddr = NW'(top_r - NCW'(1)); s_raddr = NW'(top_r - NCW'(2));
    s_wdata = {cur_u_r, cur_i_r + EW'(1)};
    o_we = 1'b0; o_waddr = NW'(depth_r); o_wdata = cur_u_r;
    o_raddr = NW'(depth_r - NCW'(1));
    d_we = 1'b0; d_waddr = v_r; d_wdata = cand_r; d_raddr = NW'(root_r);
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_xfer) begin
          if (in_ch.cmd == CMD_ADD) begin
            if (add_bad) begin
              drop_nxt = 1'b1;
            end else begin
              e_we     = 1'b1;
              ecnt_nxt = ecnt_r + EW'(1);
            end
          end else begin
            root_nxt  = '0;
            depth_nxt = '0;
          end
        end
      end
      S_ROOT: begin
        if (root_r == n_lim) begin
          reach_nxt    = '0;
          reach_nxt[0] = 1'b1;
          d_we         = 1'b1;
          d_waddr      = '0;
          d_wdata      = '0;
        end else if (visited_r[NW'(root_r)]) begin
          root_nxt = root_r + NCW'(1);
        end else begin
          visited_nxt[NW'(root_r)] = 1'b1;
          cur_u_nxt = NW'(root_r);
          cur_i_nxt = '0;
          top_nxt   = NCW'(1);
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          // finish this frame: record it and drop back to the caller
          o_we      = 1'b1;
          depth_nxt = depth_r + NCW'(1);
          top_nxt   = top_r - NCW'(1);
          if (top_r == NCW'(1)) root_nxt = root_r + NCW'(1);
        end
      end
      S_EDGE: begin
        cur_i_nxt = cur_i_r + EW'(1);
        if (push_ok) begin
          s_we                 = 1'b1;
          visited_nxt[edge_v]  = 1'b1;
          cur_u_nxt            = edge_v;
          cur_i_nxt            = '0;
          top_nxt              = top_r + NCW'(1);
        end
      end
      S_RESTORE: begin
        {cur_u_nxt, cur_i_nxt} = s_rdata;
      end
      S_ORDPOP: begin
        if (depth_r == '0) begin
          root_nxt = '0;
        end else begin
          depth_nxt = depth_r - NCW'(1);
        end
      end
      S_ORD: begin
        cur_u_nxt = o_rdata;
        d_raddr   = o_rdata;
      end
      S_DU: begin
        du_nxt    = d_rdata;
        cur_i_nxt = '0;
      end
      S_REDGE: begin
        cur_i_nxt = cur_i_r + EW'(1);
        v_nxt     = edge_v;
        cand_nxt  = (sum > DIST_MAX) ? DIST_MAX : sum;
        d_raddr   = edge_v;
      end
      S_RCMP: begin
        if (!reach_r[v_r] || cand_r < d_rdata) begin
          d_we          = 1'b1;
          reach_nxt[v_r] = 1'b1;
        end
      end
      S_LOAD: begin
        o_node_nxt = 5'(root_r);
        o_dist_nxt = reach_r[NW'(root_r)] ? d_rdata : DIST_NONE;
        o_ovf_nxt  = drop_r;
        o_last_nxt = (root_r + NCW'(1) == n_lim);
      end
      S_OWAIT: begin
        if (out_xfer) begin
          if (o_last_r) begin
            ecnt_nxt    = '0;
            drop_nxt    = 1'b0;
            visited_nxt = '0;
          end else begin
            root_nxt = root_r + NCW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid      = (state_r == S_OWAIT);
  assign out_ch.node_index = o_node_r;
  assign out_ch.distance   = o_dist_r;
  assign out_ch.overflow   = o_ovf_r;
  assign out_ch.last_node  = o_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      nodes_r   <= 6'd32;
      ecnt_r    <= '0;
      drop_r    <= 1'b0;
      visited_r <= '0;
      reach_r   <= '0;
      root_r    <= '0;
      top_r     <= '0;
      depth_r   <= '0;
      cur_u_r   <= '0;
      cur_i_r   <= '0;
      o_last_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      if (cfg_we) nodes_r <= cfg_data;
      ecnt_r    <= ecnt_nxt;
      drop_r    <= drop_nxt;
      visited_r <= visited_nxt;
      reach_r   <= reach_nxt;
      root_r    <= root_nxt;
      top_r     <= top_nxt;
      depth_r   <= depth_nxt;
      cur_u_r   <= cur_u_nxt;
      cur_i_r   <= cur_i_nxt;
      o_last_r  <= o_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r      <= v_nxt;
    cand_r   <= cand_nxt;
    du_r     <= du_nxt;
    o_node_r <= o_node_nxt;
    o_dist_r <= o_dist_nxt;
    o_ovf_r  <= o_ovf_nxt;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while results pending");
  a_ecnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ecnt_r) <= MAX_EDGES)
    else $error("edge count beyond capacity");
  a_stack_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(top_r) <= MAX_NODES && 32'(depth_r) <= MAX_NODES)
    else $error("search stack or order beyond node count");
  a_clear_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_ch.last_node |=> ecnt_r == '0 && !drop_r && visited_r == '0)
    else $error("edge store not emptied after run");
  a_source_reached: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OWAIT |-> reach_r[0])
    else $error("source node not marked reachable");

endmodule

@@ design/dsp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
